// ===== design/bounded_deque_with_search_unit_macros.svh =====
// Assertion macros for the bounded deque with search unit.
// Included by the top level; needs a clock and an active-low reset name per use.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define BDQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bdqs_pkg.sv =====
// Shared types and constants of the bounded deque with search unit.
// No dependencies; used by every other file of the block except bdqs_ram and the macro header.
`default_nettype none

package bdqs_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KIND_W       = 3;
	localparam int VALUE_W      = 32;
	localparam int STATUS_W     = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic op_en;         // apply a push/pop/no-op or an empty search, load result
		logic search_start;  // latch key and start the ring walk
		logic rd_issue;      // read the next entry of the walk
		logic search_end;    // load the search result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic count_zero;
		logic issue_more;    // entries left to read
		logic hit;           // returned entry matches the key
		logic last_cmp;      // returned entry is the last stored one
	} sts_t;

endpackage

`default_nettype wire

// ===== design/bdqs_in_if.sv =====
// Input channel of the deque unit: valid/ready handshake with kind and value.
// Depends on bdqs_pkg.
`default_nettype none

interface bdqs_in_if
	import bdqs_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

// ===== design/bdqs_out_if.sv =====
// Result channel of the deque unit: valid/ready handshake with status, found, occupancy.
// Depends on bdqs_pkg.
`default_nettype none

interface bdqs_out_if
	import bdqs_pkg::*;
#(
	parameter int OCC_W = $clog2(CAPACITY_DEF + 1)
);
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output found, output occupancy, input ready);
	modport sink   (input valid, input status, input found, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== design/bdqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bdqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/bdqs_datapath.sv =====
// Datapath of the deque unit: ring pointers, slot RAM, search walk and result register.
// Depends on bdqs_pkg and bdqs_ram.
`default_nettype none

module bdqs_datapath
	import bdqs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int IDX_W   = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cmd_t                      cmd,
	output sts_t                           sts,
	input  wire logic [KIND_W-1:0]         kind,
	input  wire logic signed [VALUE_W-1:0] value,
	output logic [STATUS_W-1:0]            res_status,
	output logic                           res_found,
	output logic [CNT_W-1:0]               res_occupancy
);

	localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W:0]   CAP_W    = (CNT_W + 1)'(CAPACITY);

	logic [IDX_W-1:0]   front_q, front_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [STATUS_W-1:0] status_d;
	logic               full, empty;
	logic [CNT_W:0]     back_sum;
	logic [IDX_W-1:0]   back_pos, front_dec, front_inc;
	logic               we;
	logic [IDX_W-1:0]   waddr;

	logic [VALUE_W-1:0] key_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   issue_left_q;
	logic               rd_valid_s1, last_s1;
	logic [VALUE_W-1:0] rdata;

	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
	// front + count stays below twice the capacity: one compare and subtract
	assign back_sum  = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
	assign back_pos  = (back_sum >= CAP_W) ? IDX_W'(back_sum - CAP_W) : IDX_W'(back_sum);

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = ST_DONE;
		we       = 1'b0;
		waddr    = back_pos;
		case (kind)
			KIND_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					front_d = front_dec;
					count_d = count_q + CNT_W'(1);
					we      = cmd.op_en;
					waddr   = front_dec;
				end
			end
			KIND_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					we      = cmd.op_en;
				end
			end
			KIND_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			KIND_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.op_en) begin
				front_q <= front_d;
				count_q <= count_d;
			end
			rd_valid_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op_en) begin
			res_status    <= status_d;
			res_found     <= 1'b0;
			res_occupancy <= count_d;
		end else if (cmd.search_end) begin
			res_status    <= ST_DONE;
			res_found     <= sts.hit;
			res_occupancy <= count_q;
		end
		if (cmd.search_start) begin
			key_q        <= value;
			rd_ptr_q     <= front_q;
			issue_left_q <= count_q;
		end else if (cmd.rd_issue) begin
			rd_ptr_q     <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + IDX_W'(1);
			issue_left_q <= issue_left_q - CNT_W'(1);
		end
		last_s1 <= (issue_left_q == CNT_W'(1));
	end

	bdqs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	assign sts.count_zero = empty;
	assign sts.issue_more = (issue_left_q != '0);
	assign sts.hit        = rd_valid_s1 && (rdata == key_q);
	assign sts.last_cmp   = rd_valid_s1 && last_s1;

endmodule

`default_nettype wire

// ===== design/bdqs_ctrl.sv =====
// Controller of the deque unit: handshake, search sequencing and result valid.
// Depends on bdqs_pkg.
`default_nettype none

module bdqs_ctrl
	import bdqs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [KIND_W-1:0] in_kind,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire sts_t              sts,
	output cmd_t                   cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_SEARCH = 1'b1;

	logic state_q, state_d;
	logic accept, is_search;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign accept    = in_valid && in_ready;
	assign is_search = (in_kind == KIND_SEARCH);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				// a search of an empty deque answers at once
				cmd.op_en        = accept && (!is_search || sts.count_zero);
				cmd.search_start = accept && is_search && !sts.count_zero;
				if (cmd.search_start) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.rd_issue   = sts.issue_more;
				cmd.search_end = sts.hit || sts.last_cmp;
				if (cmd.search_end) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op_en || cmd.search_end) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bounded_deque_with_search_unit.sv =====
// Bounded double-ended queue of signed 32-bit values with linear search.
// Channels: in_ch carries one operation per beat (kind, value); out_ch returns
// exactly one result beat (status, found, occupancy) per accepted operation,
// in order. Kinds: push front, push back, pop front, pop back, search; other
// kinds are no-ops that report done.
// Push, pop, no-op and a search of an empty deque give their result in the
// cycle after acceptance. A search over N stored values reads the slot RAM
// one entry a cycle from the front and stops at the first match; the single
// read port of the slot RAM sets this rate.
// One operation is in flight at a time: a new beat is taken once the previous
// one has finished and the result register is empty or drained in that cycle.
// A stalled receiver holds the result register and blocks further input.
// Reset empties the deque (front and count to zero); slot contents are not
// cleared, which is unobservable since only stored entries are read.
// Depends on bdqs_pkg, bdqs_in_if, bdqs_out_if, bdqs_ram, bdqs_datapath, bdqs_ctrl.
`default_nettype none
`include "bounded_deque_with_search_unit_macros.svh"

module bounded_deque_with_search_unit
	import bdqs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input wire logic     clk,
	input wire logic     arst_n,
	bdqs_in_if.sink      in_ch,
	bdqs_out_if.source   out_ch
);

	cmd_t cmd;
	sts_t sts;
	logic [CNT_W-1:0] res_occupancy;

	bdqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_kind   (in_ch.kind),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bdqs_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (in_ch.kind),
		.value         (in_ch.value),
		.res_status    (out_ch.status),
		.res_found     (out_ch.found),
		.res_occupancy (res_occupancy)
	);

	assign out_ch.occupancy = res_occupancy;

	`BDQS_ASSERT_NOW(a_occ_bound, clk, arst_n, out_ch.valid, res_occupancy <= CNT_W'(CAPACITY), "occupancy above capacity")
	`BDQS_ASSERT_NOW(a_full_occ, clk, arst_n, out_ch.valid && out_ch.status == ST_FULL, res_occupancy == CNT_W'(CAPACITY), "full status on a deque that is not full")
	`BDQS_ASSERT_NOW(a_found_ok, clk, arst_n, out_ch.valid && out_ch.found, out_ch.status == ST_DONE && res_occupancy != '0, "found reported on empty deque or bad status")
	`BDQS_ASSERT_NEXT(a_quick_op, clk, arst_n, in_ch.valid && in_ch.ready && in_ch.kind != KIND_SEARCH, out_ch.valid, "push/pop result not ready after one cycle")

endmodule

`default_nettype wire

// ===== tb/tb_bounded_deque_with_search_unit.sv =====
// Self-checking testbench for bounded_deque_with_search_unit: pushes, pops and searches
// are checked beat by beat against a mirror deque kept inside the bench.
// Depends on bdqs_pkg, bdqs_in_if, bdqs_out_if and the unit's RTL.
`timescale 1ns / 100ps

module tb_bounded_deque_with_search_unit;
	import bdqs_pkg::*;

	localparam int DEPTH        = CAPACITY_DEF;
	localparam int OCC_W        = $clog2(CAPACITY_DEF + 1);
	localparam int RANDOM_OPS   = 1900;
	localparam int SETTLE_CYCLES = DEPTH + 16;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_REPORTS  = 20;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [OCC_W-1:0]    occupancy;
	} deque_result_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_LOOKUP} op_mix_t;

	logic clk;
	logic arst_n;

	bdqs_in_if                 in_ch ();
	bdqs_out_if #(.OCC_W(OCC_W)) out_ch ();

	bounded_deque_with_search_unit #(.CAPACITY(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// mirror of the deque contents
	logic [VALUE_W-1:0] slot_mirror [DEPTH];
	int head_pos;
	int fill_level;

	deque_result_t pending_results [$];

	int n_errors;
	int n_results;
	int n_sent;
	int n_searches;
	int n_hits;
	int n_full_drops;
	int n_empty_pops;
	int peak_fill;
	int cycle_count;
	bit send_no_idle;
	int rx_stall_left;
	int rx_free_left;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// applies one operation to the mirror and queues the result it must give
	function automatic void apply_to_mirror(input logic [KIND_W-1:0] k,
		input logic [VALUE_W-1:0] v);
		deque_result_t r;
		int i;
		r.status = ST_DONE;
		r.found = 1'b0;
		r.occupancy = '0;
		case (k)
			KIND_PUSH_FRONT: begin
				if (fill_level >= DEPTH) begin
					r.status = ST_FULL;
					n_full_drops++;
				end else begin
					head_pos = (head_pos + DEPTH - 1) % DEPTH;
					slot_mirror[head_pos] = v;
					fill_level++;
				end
			end
			KIND_PUSH_BACK: begin
				if (fill_level >= DEPTH) begin
					r.status = ST_FULL;
					n_full_drops++;
				end else begin
					slot_mirror[(head_pos + fill_level) % DEPTH] = v;
					fill_level++;
				end
			end
			KIND_POP_FRONT: begin
				if (fill_level == 0) begin
					r.status = ST_EMPTY;
					n_empty_pops++;
				end else begin
					head_pos = (head_pos + 1) % DEPTH;
					fill_level--;
				end
			end
			KIND_POP_BACK: begin
				if (fill_level == 0) begin
					r.status = ST_EMPTY;
					n_empty_pops++;
				end else begin
					fill_level--;
				end
			end
			KIND_SEARCH: begin
				n_searches++;
				for (i = 0; i < fill_level; i++) begin
					if (slot_mirror[(head_pos + i) % DEPTH] == v) begin
						r.found = 1'b1;
						n_hits++;
						break;
					end
				end
			end
			default: ;
		endcase
		if (fill_level > peak_fill)
			peak_fill = fill_level;
		r.occupancy = OCC_W'(fill_level);
		pending_results.push_back(r);
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
		int gap;
		gap = send_no_idle ? 0 : pick_idle();
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.kind = k;
		in_ch.value = v;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		apply_to_mirror(k, v);
		n_sent++;
	endtask

	// sender holds off until every queued result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("[%0t] result %0d: %s got %0h, expected %0h", $realtime, n_results,
				what, got, want);
	endtask

	function automatic logic [VALUE_W-1:0] mirror_at(input int offset);
		return slot_mirror[(head_pos + offset) % DEPTH];
	endfunction

	function automatic logic [VALUE_W-1:0] pick_push_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return VALUE_W'($urandom_range(0, 7));
		if (r < 20) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_search_value();
		int r;
		logic [VALUE_W-1:0] v;
		r = $urandom_range(0, 99);
		if (fill_level > 0 && r < 70) begin
			v = mirror_at($urandom_range(0, fill_level - 1));
			// a single flipped bit is almost always a miss that walks every entry
			if (r >= 55)
				v[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
			return v;
		end
		if (r < 80)
			return VALUE_W'($urandom_range(0, 7));
		return $urandom;
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(input op_mix_t mix);
		int r;
		int push_pct;
		int pop_pct;
		int noise_pct;
		case (mix)
			MIX_FILL:     begin push_pct = 70; pop_pct = 15; noise_pct = 2; end
			MIX_DRAIN:    begin push_pct = 15; pop_pct = 62; noise_pct = 2; end
			MIX_LOOKUP:   begin push_pct = 20; pop_pct = 17; noise_pct = 3; end
			default:      begin push_pct = 35; pop_pct = 30; noise_pct = 5; end
		endcase
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
		if (r < push_pct + pop_pct)
			return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
		if (r < push_pct + pop_pct + noise_pct)
			return KIND_W'($urandom_range(KIND_SEARCH + 1, (1 << KIND_W) - 1));
		return KIND_SEARCH;
	endfunction

	task automatic test_empty_deque();
		int k;
		send_op(KIND_SEARCH, 32'h0000_0000);
		send_op(KIND_POP_FRONT, $urandom);
		send_op(KIND_POP_BACK, $urandom);
		for (k = KIND_SEARCH + 1; k < (1 << KIND_W); k++)
			send_op(KIND_W'(k), $urandom);
		send_op(KIND_SEARCH, 32'hFFFF_FFFF);
	endtask

	task automatic test_value_extremes();
		int k;
		send_op(KIND_PUSH_BACK, 32'h7FFF_FFFF);
		send_op(KIND_PUSH_FRONT, 32'h8000_0000);
		send_op(KIND_PUSH_BACK, 32'h0000_0000);
		send_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
		send_op(KIND_SEARCH, 32'h7FFF_FFFF);
		send_op(KIND_SEARCH, 32'h8000_0000);
		send_op(KIND_SEARCH, 32'h0000_0000);
		send_op(KIND_SEARCH, 32'hFFFF_FFFF);
		send_op(KIND_SEARCH, 32'h0000_0001);
		send_op(KIND_SEARCH, 32'h7FFF_FFFE);
		for (k = KIND_SEARCH + 1; k < (1 << KIND_W); k++)
			send_op(KIND_W'(k), 32'h7FFF_FFFF);
		send_op(KIND_POP_FRONT, 32'h0);
		send_op(KIND_SEARCH, 32'hFFFF_FFFF);
		send_op(KIND_POP_BACK, 32'h0);
		send_op(KIND_SEARCH, 32'h0000_0000);
		send_op(KIND_POP_BACK, 32'h0);
		send_op(KIND_POP_FRONT, 32'h0);
		send_op(KIND_POP_BACK, 32'h0);
	endtask

	// fill to capacity, push into a full deque, search the last and first slots, drain past empty
	task automatic test_capacity();
		while (fill_level < DEPTH)
			send_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom);
		send_op(KIND_PUSH_FRONT, $urandom);
		send_op(KIND_PUSH_BACK, $urandom);
		send_op(KIND_SEARCH, mirror_at(DEPTH - 1));
		send_op(KIND_SEARCH, mirror_at(0));
		send_op(KIND_SEARCH, pick_search_value());
		send_op(KIND_W'(KIND_SEARCH + 1), $urandom);
		while (fill_level > 0)
			send_op($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom);
		send_op(KIND_POP_FRONT, $urandom);
		send_op(KIND_SEARCH, 32'h0);
	endtask

	task automatic test_random_traffic(input int n_ops);
		int done_ops;
		int phase_len;
		op_mix_t mix;
		logic [KIND_W-1:0] k;
		done_ops = 0;
		while (done_ops < n_ops) begin
			mix = op_mix_t'($urandom_range(0, 3));
			phase_len = $urandom_range(40, 160);
			send_no_idle = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				k = pick_kind(mix);
				send_op(k, (k == KIND_SEARCH) ? pick_search_value() : pick_push_value());
				done_ops++;
			end
			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end
		send_no_idle = 1'b0;
	endtask

	// result side: random stalls with occasional stall-free stretches
	always @(negedge clk) begin
		if (rx_stall_left > 0) begin
			out_ch.ready = 1'b0;
			rx_stall_left--;
		end else begin
			out_ch.ready = 1'b1;
			if (rx_free_left > 0)
				rx_free_left--;
			else if ($urandom_range(0, 199) == 0)
				rx_free_left = $urandom_range(50, 300);
			else if ($urandom_range(0, 99) < 30)
				rx_stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("beat with nothing expected, status", 32'(out_ch.status), 'x);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.status !== want.status)
					report_mismatch("status", 32'(out_ch.status), 32'(want.status));
				if (out_ch.found !== want.found)
					report_mismatch("found", 32'(out_ch.found), 32'(want.found));
				if (out_ch.occupancy !== want.occupancy)
					report_mismatch("occupancy", 32'(out_ch.occupancy), 32'(want.occupancy));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_PUSH_FRONT;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		head_pos = 0;
		fill_level = 0;
		send_no_idle = 1'b0;
		rx_stall_left = 0;
		rx_free_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_deque();
		test_value_extremes();
		wait_drained();
		test_capacity();
		wait_drained();
		test_random_traffic(RANDOM_OPS);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d operations: %0d searches (%0d hits), %0d pushes into a full deque,",
			n_sent, n_searches, n_hits, n_full_drops);
		$display("%0d pops of an empty deque, peak occupancy %0d of %0d; %0d mismatches.",
			n_empty_pops, peak_fill, DEPTH, n_errors);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/bdqs_pkg.sv
design/bdqs_in_if.sv
design/bdqs_out_if.sv
design/bdqs_ram.sv
design/bdqs_datapath.sv
design/bdqs_ctrl.sv
design/bounded_deque_with_search_unit.sv
tb/tb_bounded_deque_with_search_unit.sv
